// ===== rtl/core/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the frame parser with CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Default payload storage depth in bytes
    localparam int MAX_PAYLOAD_DEF = 32;

    // Frame layout
    localparam int HDR_LEN = 7;
    localparam int CRC_LEN = 2;
    localparam int LEN_IDX = 6;
    localparam int CRC_START_IDX = 3;  // first byte count at which the CRC is fed

    // Byte counter saturates at its all-ones value
    localparam int COUNT_W = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd2;

    localparam logic [7:0] START_RST   = 8'hAA;
    localparam logic [7:0] VERSION_RST = 8'h01;
    localparam logic [8:0] MIN_LEN_RST = 9'd9;

    // CRC-16/MODBUS, reflected
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LENGTH  = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_TOO_BIG = 3'd4;
    localparam logic [2:0] ST_CRC     = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  dest_addr;
        logic [7:0]  src_addr;
        logic [7:0]  command;
        logic [7:0]  sequence_res;
        logic [7:0]  payload_len;
        logic [15:0] received_crc;
        logic [7:0]  payload_byte;
        logic        is_payload;
        logic        last_result;
    } t_out_word;

endpackage

// ===== rtl/core/frame_parser_crc16_check.sv =====
// ----------------------------------------------------------------------------
// frame_parser_crc16_check
// Byte-wise frame receiver: header capture, CRC-16/MODBUS check, payload replay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one frame byte per
//   word; frame_end marks the closing byte. Output channel (o_out_valid /
//   i_out_ready / o_out) carries one result word.
//   The closing byte of a frame produces a status word in the cycle after it is
//   accepted. After an ok frame with L payload bytes, each of the next L input
//   words is consumed without being parsed and returns one stored payload byte
//   (last_result on the final one). Other bytes produce no result.
//   Throughput: one input word per cycle unless a stalled receiver holds it, as
//   below. The payload byte for a replay word is prefetched from the payload
//   RAM the cycle before, so its registered read port costs nothing.
//   When the receiver stalls, the result waits in the output register; input
//   words that produce no result are still taken, those that would produce one
//   wait until the output register frees up.
//   Reset (synchronous, active low) restores the register defaults and clears
//   the frame counters and replay state; the header store and payload RAM are not cleared.
//   Configuration writes are applied at once and belong between frames.
// ----------------------------------------------------------------------------
module frame_parser_crc16_check #(
    parameter int MAX_PAYLOAD = fpc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // byte input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fpc_pkg::t_in_word                i_in,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fpc_pkg::t_out_word               o_out
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam int HW = $clog2(fpc_pkg::HDR_LEN);
    localparam logic [fpc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // CRC-16/MODBUS update for one byte, LSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ fpc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // configuration registers
    logic [7:0] r_start_byte;
    logic [7:0] r_version_byte;
    logic [8:0] r_min_len;

    // frame state
    logic [fpc_pkg::COUNT_W-1:0] r_byte_count;
    logic [15:0]                 r_crc;
    logic [15:0]                 r_tail;
    logic [7:0]                  r_hdr [fpc_pkg::HDR_LEN];
    logic [7:0]                  n_hdr [fpc_pkg::HDR_LEN];

    // replay state
    logic [PW-1:0] r_drain_pos;
    logic [PW-1:0] n_drain_pos;
    logic [7:0]    r_drain_left;

    // output register
    logic                r_out_valid;
    fpc_pkg::t_out_word  r_out;
    fpc_pkg::t_out_word  n_out;

    logic draining;
    logic makes_result;
    logic in_acc;
    logic byte_acc;
    logic out_load;

    logic [15:0] crc_fed;
    logic [15:0] crc_next;
    logic [15:0] rx_crc;
    logic [9:0]  frame_len;
    logic [9:0]  frame_len_hdr;
    logic [7:0]  pay_len;
    logic [2:0]  status;

    logic [fpc_pkg::COUNT_W-1:0] pay_off;
    logic                        ram_we;
    logic [7:0]                  ram_rdata;

    // handshake
    assign draining     = (r_drain_left != 8'd0);
    assign makes_result = draining || i_in.frame_end;
    assign o_in_ready   = !r_out_valid || i_out_ready || !makes_result;
    assign in_acc       = i_in_valid && o_in_ready;
    assign byte_acc     = in_acc && !draining;
    assign out_load     = in_acc && makes_result;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= fpc_pkg::START_RST;
            r_version_byte <= fpc_pkg::VERSION_RST;
            r_min_len      <= fpc_pkg::MIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpc_pkg::CFG_START:   r_start_byte   <= i_cfg_data[7:0];
                fpc_pkg::CFG_VERSION: r_version_byte <= i_cfg_data[7:0];
                fpc_pkg::CFG_MIN_LEN: r_min_len      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // header capture, this byte included
    always_comb begin
        for (int h = 0; h < fpc_pkg::HDR_LEN; h++) begin
            n_hdr[h] = r_hdr[h];
        end
        if (byte_acc && (r_byte_count < fpc_pkg::COUNT_W'(fpc_pkg::HDR_LEN))) begin
            n_hdr[r_byte_count[HW-1:0]] = i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    // running CRC lags two bytes so the trailing CRC is left out
    assign crc_fed  = crc16_feed(r_crc, r_tail[15:8]);
    assign crc_next = (r_byte_count >= fpc_pkg::COUNT_W'(fpc_pkg::CRC_START_IDX)) ?
                      crc_fed : r_crc;
    assign rx_crc   = {i_in.rx_byte, r_tail[7:0]};

    // frame checks on the closing byte
    assign frame_len     = {1'b0, r_byte_count} + 10'd1;
    assign pay_len       = n_hdr[fpc_pkg::LEN_IDX];
    assign frame_len_hdr = 10'(fpc_pkg::HDR_LEN + fpc_pkg::CRC_LEN) + {2'b00, pay_len};

    always_comb begin
        if ((frame_len < {1'b0, r_min_len}) || (frame_len < 10'(fpc_pkg::HDR_LEN))) begin
            status = fpc_pkg::ST_LENGTH;
        end else if (n_hdr[0] != r_start_byte) begin
            status = fpc_pkg::ST_START;
        end else if (n_hdr[1] != r_version_byte) begin
            status = fpc_pkg::ST_VERSION;
        end else if ({2'b00, pay_len} > 10'(MAX_PAYLOAD)) begin
            status = fpc_pkg::ST_TOO_BIG;
        end else if (frame_len != frame_len_hdr) begin
            status = fpc_pkg::ST_LENGTH;
        end else if (rx_crc != crc_next) begin
            status = fpc_pkg::ST_CRC;
        end else begin
            status = fpc_pkg::ST_OK;
        end
    end

    // frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= fpc_pkg::CRC_INIT;
            r_tail       <= '0;
        end else if (byte_acc) begin
            if (i_in.frame_end) begin
                r_byte_count <= '0;
                r_crc        <= fpc_pkg::CRC_INIT;
                r_tail       <= '0;
            end else begin
                if (r_byte_count != COUNT_MAX) begin
                    r_byte_count <= r_byte_count + fpc_pkg::COUNT_W'(1);
                end
                r_crc  <= crc_next;
                r_tail <= {r_tail[7:0], i_in.rx_byte};
            end
        end
    end

    // payload store write
    assign pay_off = r_byte_count - fpc_pkg::COUNT_W'(fpc_pkg::HDR_LEN);
    assign ram_we  = byte_acc
                  && (r_byte_count >= fpc_pkg::COUNT_W'(fpc_pkg::HDR_LEN))
                  && (pay_off < fpc_pkg::COUNT_W'(MAX_PAYLOAD));

    // replay position; the RAM always reads the next position
    always_comb begin
        n_drain_pos = r_drain_pos;
        if (in_acc && draining) begin
            n_drain_pos = r_drain_pos + PW'(1);
        end else if (byte_acc && i_in.frame_end) begin
            n_drain_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_pos  <= '0;
            r_drain_left <= '0;
        end else begin
            r_drain_pos <= n_drain_pos;
            if (in_acc && draining) begin
                r_drain_left <= r_drain_left - 8'd1;
            end else if (byte_acc && i_in.frame_end && (status == fpc_pkg::ST_OK)) begin
                r_drain_left <= pay_len;
            end
        end
    end

    fpc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pay_off[AW-1:0]),
        .i_wdata (i_in.rx_byte),
        .i_raddr (n_drain_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // result word
    always_comb begin
        n_out = '0;
        if (draining) begin
            n_out.payload_byte = ram_rdata;
            n_out.is_payload   = 1'b1;
            n_out.last_result  = (r_drain_left == 8'd1);
        end else begin
            n_out.status = status;
            if (status == fpc_pkg::ST_OK) begin
                n_out.dest_addr    = n_hdr[2];
                n_out.src_addr     = n_hdr[3];
                n_out.command      = n_hdr[4];
                n_out.sequence_res = n_hdr[5];
                n_out.payload_len  = pay_len;
                n_out.received_crc = rx_crc;
            end
            n_out.last_result = (status != fpc_pkg::ST_OK) || (pay_len == 8'd0);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // no payload write while stored bytes are being replayed
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draining |-> !ram_we)
        else $error("payload RAM written during replay");

    // replay never runs past the stored payload
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draining |-> ((10'(r_drain_pos) + 10'(r_drain_left)) <= 10'(MAX_PAYLOAD)))
        else $error("replay exceeds payload storage");

    // an ok closing byte arms the replay with the frame's payload length
    a_drain_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_acc && i_in.frame_end && (status == fpc_pkg::ST_OK))
        |=> (r_drain_left == $past(pay_len)) && (r_drain_pos == '0))
        else $error("replay not armed after ok frame");

    // failed frames close at once with an empty header
    a_fail_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.is_payload && (o_out.status != fpc_pkg::ST_OK))
        |-> (o_out.last_result && (o_out.payload_len == 8'd0)
             && (o_out.received_crc == 16'd0)))
        else $error("failed frame status word malformed");

    // payload words carry no status
    a_payload_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_payload) |-> (o_out.status == fpc_pkg::ST_OK))
        else $error("payload word with status set");
`endif

endmodule

// ===== rtl/core/fpc_ram.sv =====
// ----------------------------------------------------------------------------
// fpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/fpc_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_result_checker
// Watches both channels of the frame parser, predicts every result word from
// the accepted byte words and the register writes, and compares field by field.
// ----------------------------------------------------------------------------
module fpc_result_checker #(
    parameter int MAX_PAY = fpc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  fpc_pkg::t_in_word              i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  fpc_pkg::t_out_word             i_out,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_frames_ok,
    output int                             o_frames_bad,
    output int                             o_payload_words
);

    // register copies
    logic [7:0]         want_start;
    logic [7:0]         want_version;
    logic [8:0]         min_len;

    // parser state
    logic [fpc_pkg::COUNT_W-1:0] byte_cnt;
    logic [7:0]         hdr_bytes [fpc_pkg::HDR_LEN];
    logic [7:0]         pay_bytes [MAX_PAY];
    logic [15:0]        crc_acc;
    logic [15:0]        tail;
    int                 replay_pos;
    int                 replay_left;

    fpc_pkg::t_out_word want_results [$];

    // one byte of CRC-16/MODBUS, reflected
    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ fpc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_frame();
        byte_cnt = '0;
        crc_acc  = fpc_pkg::CRC_INIT;
        tail     = '0;
    endtask

    task automatic reset_model();
        want_start      = fpc_pkg::START_RST;
        want_version    = fpc_pkg::VERSION_RST;
        min_len         = fpc_pkg::MIN_LEN_RST;
        replay_pos      = 0;
        replay_left     = 0;
        o_fail_count    = 0;
        o_frames_ok     = 0;
        o_frames_bad    = 0;
        o_payload_words = 0;
        for (int k = 0; k < fpc_pkg::HDR_LEN; k++) hdr_bytes[k] = '0;
        for (int k = 0; k < MAX_PAY; k++) pay_bytes[k] = '0;
        want_results.delete();
        clear_frame();
    endtask

    // predict what one accepted byte word causes
    task automatic parse_word(input fpc_pkg::t_in_word w);
        fpc_pkg::t_out_word r;
        int          idx;
        int          n;
        logic [7:0]  len;
        logic [15:0] rx_crc;
        logic [2:0]  st;
        r = '0;
        if (replay_left > 0) begin
            // replay word: input is dropped, a stored payload byte goes out
            r.payload_byte = (replay_pos < MAX_PAY) ? pay_bytes[replay_pos] : 8'h00;
            r.is_payload   = 1'b1;
            r.last_result  = (replay_left == 1);
            replay_pos++;
            replay_left--;
            want_results.push_back(r);
        end else begin
            idx = byte_cnt;
            if (idx < fpc_pkg::HDR_LEN)
                hdr_bytes[idx] = w.rx_byte;
            else if (idx - fpc_pkg::HDR_LEN < MAX_PAY)
                pay_bytes[idx - fpc_pkg::HDR_LEN] = w.rx_byte;
            // CRC trails the input by two bytes so the CRC field stays out
            if (idx >= fpc_pkg::CRC_START_IDX) crc_acc = crc16_step(crc_acc, tail[15:8]);
            tail = {tail[7:0], w.rx_byte};
            if (byte_cnt != {fpc_pkg::COUNT_W{1'b1}}) byte_cnt++;

            if (w.frame_end) begin
                n      = idx + 1;
                len    = hdr_bytes[fpc_pkg::LEN_IDX];
                rx_crc = {tail[7:0], tail[15:8]};
                if (n < min_len || n < fpc_pkg::HDR_LEN)
                    st = fpc_pkg::ST_LENGTH;
                else if (hdr_bytes[0] != want_start)
                    st = fpc_pkg::ST_START;
                else if (hdr_bytes[1] != want_version)
                    st = fpc_pkg::ST_VERSION;
                else if (len > MAX_PAY)
                    st = fpc_pkg::ST_TOO_BIG;
                else if (n != fpc_pkg::HDR_LEN + len + fpc_pkg::CRC_LEN)
                    st = fpc_pkg::ST_LENGTH;
                else if (rx_crc != crc_acc)
                    st = fpc_pkg::ST_CRC;
                else
                    st = fpc_pkg::ST_OK;
                r.status = st;
                if (st == fpc_pkg::ST_OK) begin
                    r.dest_addr    = hdr_bytes[2];
                    r.src_addr     = hdr_bytes[3];
                    r.command      = hdr_bytes[4];
                    r.sequence_res = hdr_bytes[5];
                    r.payload_len  = len;
                    r.received_crc = rx_crc;
                    replay_pos     = 0;
                    replay_left    = len;
                end
                r.last_result = (st != fpc_pkg::ST_OK || len == 0);
                want_results.push_back(r);
                clear_frame();
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    task automatic compare_result(input fpc_pkg::t_out_word got);
        fpc_pkg::t_out_word want;
        if (want_results.size() == 0) begin
            o_fail_count++;
            $display("%0t: result word with none expected, expected nothing, actual %h",
                     $time, got);
        end else begin
            want = want_results.pop_front();
            check_field("status",       want.status,       got.status);
            check_field("dest_addr",    want.dest_addr,    got.dest_addr);
            check_field("src_addr",     want.src_addr,     got.src_addr);
            check_field("command",      want.command,      got.command);
            check_field("sequence_res", want.sequence_res, got.sequence_res);
            check_field("payload_len",  want.payload_len,  got.payload_len);
            check_field("received_crc", want.received_crc, got.received_crc);
            check_field("payload_byte", want.payload_byte, got.payload_byte);
            check_field("is_payload",   want.is_payload,   got.is_payload);
            check_field("last_result",  want.last_result,  got.last_result);
            if (want.is_payload)                    o_payload_words++;
            else if (want.status == fpc_pkg::ST_OK) o_frames_ok++;
            else                                    o_frames_bad++;
        end
    endtask

    // everything is sampled at the rising edge; results before new bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fpc_pkg::CFG_START:   want_start   = i_cfg_data[7:0];
                    fpc_pkg::CFG_VERSION: want_version = i_cfg_data[7:0];
                    fpc_pkg::CFG_MIN_LEN: min_len      = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) compare_result(i_out);
            if (i_in_valid && i_in_ready) parse_word(i_in);
        end
        o_pending = want_results.size();
    end

endmodule

// ===== bench/frame_parser_crc16_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_parser_crc16_check_tb
// Feeds framed byte streams through the parser under several register
// settings: well-formed frames with payload replay, broken frames of each
// kind, short, noisy and overlong frames, with random gaps on both channels
// and long output stalls. Checking is done by fpc_result_checker.
// ----------------------------------------------------------------------------
module frame_parser_crc16_check_tb;

    localparam int MAX_PAY         = fpc_pkg::MAX_PAYLOAD_DEF;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int NUM_PHASES      = 5;
    localparam int WORDS_PER_PHASE = 180;
    localparam int STALL_HOLD      = 250;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int OVERLONG_BODY   = 513;

    typedef enum int {
        FR_GOOD, FR_BAD_START, FR_BAD_VERSION, FR_TOO_BIG, FR_LEN_OFF,
        FR_BAD_CRC, FR_SHORT, FR_NOISE, FR_OVERLONG
    } t_frame_kind;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [fpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [fpc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    fpc_pkg::t_in_word              i_in        = '0;
    logic                           i_out_ready = 1'b0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    fpc_pkg::t_out_word             o_out;

    int chk_fails;
    int chk_pending;
    int chk_ok;
    int chk_bad;
    int chk_payload;

    // current register settings, used to build frames
    logic [7:0] cur_start   = fpc_pkg::START_RST;
    logic [7:0] cur_version = fpc_pkg::VERSION_RST;
    logic [8:0] cur_min_len = fpc_pkg::MIN_LEN_RST;

    logic [7:0] frame_q [$];
    int         words_sent  = 0;
    int         idle_cycles = 0;
    int         hold_asks   = 0;
    int         holds_done  = 0;
    bit         send_burst  = 1'b0;
    bit         recv_burst  = 1'b0;

    frame_parser_crc16_check #(
        .MAX_PAYLOAD (MAX_PAY)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    fpc_result_checker #(
        .MAX_PAY (MAX_PAY)
    ) i_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in            (i_in),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out           (o_out),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending),
        .o_frames_ok     (chk_ok),
        .o_frames_bad    (chk_bad),
        .o_payload_words (chk_payload)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("frame_parser_crc16_check_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random ready gaps, bursts without gaps, long holds on request
    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n);
        forever begin
            if (taken % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
            if (holds_done < hold_asks) begin
                gap = STALL_HOLD;
                holds_done++;
            end else begin
                gap = recv_burst ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    function automatic logic [15:0] frame_crc_byte(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ fpc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] fill_byte(int fill);
        logic [7:0] b;
        b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
        return b;
    endfunction

    // offer one byte word and wait for it to be taken
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= '{rx_byte: b, frame_end: last};
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // build one frame of the given kind; ok says whether the parser accepts it
    task automatic build_frame(input t_frame_kind kind, input int len, input int fill,
                               output bit ok);
        int          n;
        int          body;
        logic [15:0] crc;
        frame_q.delete();
        ok = 1'b0;
        if (kind == FR_NOISE || kind == FR_SHORT) begin
            n = (kind == FR_NOISE) ? $urandom_range(1, 45)
                                   : $urandom_range(1, fpc_pkg::HDR_LEN + 1);
            repeat (n) frame_q.push_back(fill_byte(fill));
            if (kind == FR_SHORT) begin
                frame_q[0] = cur_start;
                if (n > 1) frame_q[1] = cur_version;
            end
        end else begin
            frame_q.push_back((kind == FR_BAD_START)
                              ? cur_start ^ 8'($urandom_range(1, 255)) : cur_start);
            frame_q.push_back((kind == FR_BAD_VERSION)
                              ? cur_version ^ 8'($urandom_range(1, 255)) : cur_version);
            repeat (4) frame_q.push_back(fill_byte(fill));
            frame_q.push_back(len[7:0]);
            case (kind)
                FR_TOO_BIG:  body = $urandom_range(0, 12);
                FR_OVERLONG: body = OVERLONG_BODY;
                default:     body = len;
            endcase
            repeat (body) frame_q.push_back(fill_byte(fill));
            if (kind == FR_LEN_OFF) begin
                if (len > 0 && $urandom_range(0, 1))
                    void'(frame_q.pop_back());
                else
                    repeat ($urandom_range(1, 3)) frame_q.push_back(fill_byte(-1));
            end
            crc = fpc_pkg::CRC_INIT;
            for (int k = 1; k < frame_q.size(); k++) crc = frame_crc_byte(crc, frame_q[k]);
            if (kind == FR_BAD_CRC) crc ^= (16'h0001 << $urandom_range(0, 15));
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
            ok = (kind == FR_GOOD) && (frame_q.size() >= cur_min_len);
        end
    endtask

    // send a frame and, when it passes, the words that pull out its payload
    task automatic run_frame(input t_frame_kind kind, input int len, input int fill);
        bit ok;
        send_burst = ($urandom_range(0, 3) == 0);
        build_frame(kind, len, fill, ok);
        foreach (frame_q[k]) send_word(frame_q[k], k == frame_q.size() - 1);
        if (ok) repeat (len) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_frame();
        int          r;
        int          len;
        t_frame_kind kind;
        r = $urandom_range(0, 99);
        if (r < 60)      kind = FR_GOOD;
        else if (r < 66) kind = FR_BAD_START;
        else if (r < 72) kind = FR_BAD_VERSION;
        else if (r < 78) kind = FR_TOO_BIG;
        else if (r < 85) kind = FR_LEN_OFF;
        else if (r < 92) kind = FR_BAD_CRC;
        else if (r < 96) kind = FR_SHORT;
        else             kind = FR_NOISE;
        if (kind == FR_TOO_BIG)
            len = $urandom_range(MAX_PAY + 1, 255);
        else if ($urandom_range(0, 9) < 8)
            len = $urandom_range(0, 6);
        else
            len = $urandom_range(7, MAX_PAY);
        run_frame(kind, len, -1);
    endtask

    // stop offering and let the last result and any trailing work finish
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] s, input logic [7:0] v, input logic [8:0] m);
        logic spare;
        spare = $urandom_range(0, 1);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= fpc_pkg::CFG_START;
        i_cfg_data <= {spare, s};
        @(negedge i_clk);
        i_cfg_idx  <= fpc_pkg::CFG_VERSION;
        i_cfg_data <= {~spare, v};
        @(negedge i_clk);
        i_cfg_idx  <= fpc_pkg::CFG_MIN_LEN;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_start   = s;
        cur_version = v;
        cur_min_len = m;
    endtask

    initial begin : stimulus
        int phase;
        int phase_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under reset settings; a full header comes first
        run_frame(FR_GOOD, 0, 8'h00);
        run_frame(FR_GOOD, 1, 8'hFF);
        run_frame(FR_SHORT, 0, -1);
        run_frame(FR_BAD_START, 0, -1);
        run_frame(FR_BAD_VERSION, 0, -1);
        run_frame(FR_TOO_BIG, 255, -1);
        run_frame(FR_TOO_BIG, MAX_PAY + 1, -1);
        run_frame(FR_LEN_OFF, 0, -1);
        run_frame(FR_BAD_CRC, 2, -1);
        run_frame(FR_GOOD, MAX_PAY, -1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: set_regs(8'h00, 8'h00, 9'd0);      // min length below the header
                    2: set_regs(8'hFF, 8'hFF, 9'd264);
                    3: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                9'(fpc_pkg::MIN_LEN_RST + $urandom_range(0, 20)));
                    default: set_regs(8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), fpc_pkg::MIN_LEN_RST);
                endcase
                run_frame(FR_SHORT, 0, -1);
            end
            if (phase == 0 || phase == 3) hold_asks++;
            if (phase == 3) run_frame(FR_OVERLONG, $urandom_range(0, 8), -1);
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE) random_frame();
        end

        wait_idle();
        $display("Sent %0d byte words over %0d register settings: good, broken, short,",
                 words_sent, NUM_PHASES);
        $display("noisy and overlong frames; %0d ok, %0d rejected, %0d payload words checked.",
                 chk_ok, chk_bad, chk_payload);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("frame_parser_crc16_check_tb OK");
        end else begin
            $display("frame_parser_crc16_check_tb NOT OK");
        end
        $finish;
    end

endmodule
